// File: rtl/c8_pkg.sv
// Shared types, constants and the font table for the CHIP-8 step unit.
`timescale 1ns / 1ps
package c8_pkg;

    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int MEM_BYTES         = 4096;

    localparam logic [11:0] PROG_START = 12'h200;
    localparam logic [11:0] GLYPH_BASE = 12'h050;
    localparam logic [6:0]  GLYPH_LEN  = 7'd80;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_ROW   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [15:0] keys;
        logic [7:0]  rnd_byte;
        logic [4:0]  row_sel;
    } t_req;

    typedef struct packed {
        logic [11:0] pc_now;
        logic [15:0] last_opcode;
        logic        bad_opcode;
        logic        key_wait;
        logic        beep;
        logic [63:0] row_pixels;
    } t_rsp;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_WRITE, ST_ROWRD, ST_ROWOUT,
        ST_FETCH_HI, ST_FETCH_LO, ST_FETCH_W, ST_EXEC,
        ST_STK_RD, ST_STK_W,
        ST_DRAW_RD, ST_DRAW_W, ST_DRAW_ROW, ST_DRAW_WR,
        ST_CLS, ST_BCD_DIV, ST_BCD_WR,
        ST_BLK_ST, ST_BLK_RD, ST_BLK_W, ST_BLK_LD,
        ST_DONE, ST_OUT
    } t_state;

    function automatic logic [7:0] glyph(input logic [6:0] a);
        logic [7:0] g;
        case (a)
            7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25,
            7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44,
            7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72,
            7'd74, 7'd75, 7'd77: g = 8'hF0;
            7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
            7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: g = 8'h90;
            7'd5, 7'd7, 7'd8, 7'd37: g = 8'h20;
            7'd6: g = 8'h60;
            7'd9: g = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: g = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76,
            7'd78, 7'd79: g = 8'h80;
            7'd38, 7'd39: g = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69: g = 8'hE0;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/c8_alu.sv
// Shared 8-bit ALU for register arithmetic, logic, shifts and compares.
`timescale 1ns / 1ps
module c8_alu (
    input  logic [3:0] i_op,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output logic [7:0] o_res,
    output logic       o_flag
);
    import c8_pkg::*;

    logic [8:0] w_sum;

    always_comb begin
        w_sum  = 9'd0;
        o_res  = 8'd0;
        o_flag = 1'b0;
        case (i_op)
            4'h0: o_res = i_b;
            4'h1: o_res = i_a | i_b;
            4'h2: o_res = i_a & i_b;
            4'h3: o_res = i_a ^ i_b;
            4'h4: begin
                w_sum  = {1'b0, i_a} + {1'b0, i_b};
                o_res  = w_sum[7:0];
                o_flag = w_sum[8];
            end
            4'h5: begin
                o_res  = i_a - i_b;
                o_flag = (i_a >= i_b);
            end
            4'h6: begin
                o_res  = {1'b0, i_a[7:1]};
                o_flag = i_a[0];
            end
            4'h7: begin
                o_res  = i_b - i_a;
                o_flag = (i_b >= i_a);
            end
            4'hE: begin
                o_res  = {i_a[6:0], 1'b0};
                o_flag = i_a[7];
            end
            default: begin
                o_res  = 8'd0;
                o_flag = (i_a == i_b);
            end
        endcase
    end

endmodule

// File: rtl/chip8_instruction_step_unit.sv
// Top level of the CHIP-8 step unit: sequencer, memories and register file.
`timescale 1ns / 1ps
// One request in, one response out. Memory writes, row reads and steps each run
// through a chain of states; a sprite draw works row by row, block store and
// block load go register by register, a clear screen goes display row by
// display row and BCD works by repeated subtraction, all bounded by the single
// byte port of program memory. After reset a clearing pass loads the font and
// zeros program memory before the first request is taken.
module chip8_instruction_step_unit #(
    parameter int SCREEN_WIDTH  = c8_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = c8_pkg::SCREEN_HEIGHT_DEF,
    parameter int STACK_DEPTH   = c8_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  c8_pkg::t_req  i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output c8_pkg::t_rsp  o_rsp
);
    import c8_pkg::*;

    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);

    t_state r_st, n_st;

    logic [7:0]  r_mem [MEM_BYTES];
    logic [SCREEN_WIDTH-1:0] r_fb [SCREEN_HEIGHT];
    logic [11:0] r_stk [STACK_DEPTH];
    logic [7:0]  r_v [16];

    logic        w_mem_we;
    logic [11:0] w_mem_a;
    logic [7:0]  w_mem_d;
    logic [7:0]  r_mem_q;

    logic        w_fb_we;
    logic [YW-1:0] w_fb_a;
    logic [SCREEN_WIDTH-1:0] w_fb_d;
    logic [SCREEN_WIDTH-1:0] r_fb_q;

    logic        w_stk_we;
    logic [SW-1:0] w_stk_a;
    logic [11:0] r_stk_q;

    t_req  r_req, n_req;
    t_rsp  r_rsp, n_rsp;
    logic [11:0] r_pc, n_pc;
    logic [15:0] r_op, n_op;
    logic [15:0] r_i, n_i;
    logic [LW-1:0] r_sl, n_sl;
    logic [7:0]  r_dt, n_dt, r_snd, n_snd;
    logic [11:0] r_cnt, n_cnt;
    logic [7:0]  r_t, n_t;
    logic [7:0]  r_sp, n_sp;
    logic        r_hit, n_hit, r_bad, n_bad, r_wait, n_wait;

    logic        w_v_we;
    logic [3:0]  w_v_a;
    logic [7:0]  w_v_d;
    logic        w_vf_we;
    logic [7:0]  w_vf_d;

    logic [3:0]  w_alu_op;
    logic [7:0]  w_alu_a, w_alu_b, w_alu_r;
    logic        w_alu_f;

    logic [3:0]  w_x, w_y, w_n;
    logic [7:0]  w_nn;
    logic [11:0] w_nnn, w_pc2;
    logic [7:0]  w_vx, w_vy;
    logic [XW-1:0] w_x0;
    logic [YW-1:0] w_py;
    logic [2*SCREEN_WIDTH-1:0] w_spr;
    logic [SCREEN_WIDTH-1:0] w_mask;
    logic [4:0]  w_key;
    logic        w_keyf;

    c8_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_r),
        .o_flag(w_alu_f)
    );

    assign w_x   = r_op[11:8];
    assign w_y   = r_op[7:4];
    assign w_n   = r_op[3:0];
    assign w_nn  = r_op[7:0];
    assign w_nnn = r_op[11:0];
    assign w_vx  = r_v[w_x];
    assign w_vy  = r_v[w_y];
    assign w_pc2 = r_pc + 12'd2;
    assign w_x0  = XW'(w_vx % SCREEN_WIDTH);
    assign w_py  = YW'((32'(w_vy % SCREEN_HEIGHT) + 32'(r_cnt[3:0])) % SCREEN_HEIGHT);
    assign w_spr = (2*SCREEN_WIDTH)'({r_mem_q[0], r_mem_q[1], r_mem_q[2], r_mem_q[3],
                   r_mem_q[4], r_mem_q[5], r_mem_q[6], r_mem_q[7]}) << w_x0;
    assign w_mask = w_spr[SCREEN_WIDTH-1:0] | w_spr[2*SCREEN_WIDTH-1:SCREEN_WIDTH];

    always_comb begin
        w_key  = 5'd16;
        w_keyf = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (r_req.keys[k]) begin
                w_key  = 5'(k);
                w_keyf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_a] <= w_mem_d;
        end
        r_mem_q <= r_mem[w_mem_a];
        if (w_fb_we) begin
            r_fb[w_fb_a] <= w_fb_d;
        end
        r_fb_q <= r_fb[w_fb_a];
        if (w_stk_we) begin
            r_stk[w_stk_a] <= r_pc;
        end
        r_stk_q <= r_stk[w_stk_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_v[k] <= 8'd0;
            end
        end else begin
            for (int k = 0; k < 16; k++) begin
                if (w_vf_we && k == 15) begin
                    r_v[k] <= w_vf_d;
                end else if (w_v_we && w_v_a == 4'(k)) begin
                    r_v[k] <= w_v_d;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_INIT;
            r_pc  <= PROG_START;
            r_i   <= 16'd0;
            r_sl  <= '0;
            r_dt  <= 8'd0;
            r_snd <= 8'd0;
            r_cnt <= 12'd0;
        end else begin
            r_st  <= n_st;
            r_pc  <= n_pc;
            r_i   <= n_i;
            r_sl  <= n_sl;
            r_dt  <= n_dt;
            r_snd <= n_snd;
            r_cnt <= n_cnt;
        end
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_op   <= n_op;
        r_t    <= n_t;
        r_sp   <= n_sp;
        r_hit  <= n_hit;
        r_bad  <= n_bad;
        r_wait <= n_wait;
    end

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = (r_st == ST_OUT);
    assign o_rsp   = r_rsp;

    always_comb begin
        n_st = r_st; n_req = r_req; n_rsp = r_rsp; n_pc = r_pc; n_op = r_op;
        n_i = r_i; n_sl = r_sl; n_dt = r_dt; n_snd = r_snd; n_cnt = r_cnt;
        n_t = r_t; n_sp = r_sp; n_hit = r_hit; n_bad = r_bad; n_wait = r_wait;
        w_mem_we = 1'b0; w_mem_a = r_pc; w_mem_d = 8'd0;
        w_fb_we = 1'b0; w_fb_a = w_py; w_fb_d = r_fb_q ^ w_mask;
        w_stk_we = 1'b0; w_stk_a = SW'(r_sl - LW'(1));
        w_v_we = 1'b0; w_v_a = w_x; w_v_d = 8'd0; w_vf_we = 1'b0; w_vf_d = 8'd0;
        w_alu_op = w_n; w_alu_a = w_vx; w_alu_b = w_vy;
        unique case (r_st)
            ST_INIT: begin
                w_mem_we = 1'b1;
                w_mem_a  = r_cnt;
                w_mem_d  = (r_cnt >= GLYPH_BASE && r_cnt < GLYPH_BASE + 12'(GLYPH_LEN))
                         ? glyph(7'(r_cnt - GLYPH_BASE)) : 8'd0;
                w_fb_we  = 1'b1;
                w_fb_a   = YW'(r_cnt);
                w_fb_d   = '0;
                n_cnt    = r_cnt + 12'd1;
                if (r_cnt == 12'hFFF) begin
                    n_st = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_req = i_req;
                n_rsp = '0;
                n_bad = 1'b0; n_wait = 1'b0;
                if (i_valid) begin
                    unique case (i_req.func)
                        FUNC_WRITE: n_st = ST_WRITE;
                        FUNC_STEP:  n_st = ST_FETCH_HI;
                        FUNC_ROW:   n_st = ST_ROWRD;
                        default:    n_st = ST_DONE;
                    endcase
                end
            end
            ST_WRITE: begin
                w_mem_we = 1'b1;
                w_mem_a  = r_req.mem_addr;
                w_mem_d  = r_req.mem_data;
                n_st     = ST_DONE;
            end
            ST_ROWRD: begin
                w_fb_a = YW'(r_req.row_sel);
                n_st   = ST_ROWOUT;
            end
            ST_ROWOUT: begin
                if (32'(r_req.row_sel) < SCREEN_HEIGHT) begin
                    n_rsp.row_pixels = 64'(r_fb_q);
                end
                n_st = ST_DONE;
            end
            ST_FETCH_HI: begin
                w_mem_a = r_pc;
                n_st    = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                w_mem_a = r_pc + 12'd1;
                n_op    = {r_mem_q, 8'd0};
                n_st    = ST_FETCH_W;
            end
            ST_FETCH_W: begin
                n_op = {r_op[15:8], r_mem_q};
                n_pc = w_pc2;
                n_st = ST_EXEC;
            end
            ST_EXEC: begin
                n_st  = ST_DONE;
                n_cnt = 12'd0;
                unique case (r_op[15:12])
                    4'h0: begin
                        if (r_op == 16'h00E0) begin
                            n_st = ST_CLS;
                        end else if (r_op == 16'h00EE) begin
                            if (r_sl != '0) begin
                                n_sl = r_sl - LW'(1);
                                n_st = ST_STK_RD;
                            end
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    4'h1: n_pc = w_nnn;
                    4'h2: begin
                        if (32'(r_sl) < STACK_DEPTH) begin
                            w_stk_we = 1'b1;
                            w_stk_a  = SW'(r_sl);
                            n_sl     = r_sl + LW'(1);
                            n_pc     = w_nnn;
                        end
                    end
                    4'h3: if (w_vx == w_nn) n_pc = w_pc2;
                    4'h4: if (w_vx != w_nn) n_pc = w_pc2;
                    4'h5, 4'h9: begin
                        w_alu_op = 4'hF;
                        if (w_n != 4'd0) begin
                            n_bad = 1'b1;
                        end else if (w_alu_f == (r_op[15:12] == 4'h5)) begin
                            n_pc = w_pc2;
                        end
                    end
                    4'h6: begin
                        w_v_we = 1'b1; w_v_d = w_nn;
                    end
                    4'h7: begin
                        w_v_we = 1'b1; w_v_d = w_vx + w_nn;
                    end
                    4'h8: begin
                        case (w_n)
                            4'h0, 4'h1, 4'h2, 4'h3: begin
                                w_v_we = 1'b1; w_v_d = w_alu_r;
                            end
                            4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                                w_v_we = 1'b1; w_v_d = w_alu_r;
                                w_vf_we = 1'b1; w_vf_d = {7'd0, w_alu_f};
                            end
                            default: n_bad = 1'b1;
                        endcase
                    end
                    4'hA: n_i = {4'd0, w_nnn};
                    4'hB: n_pc = w_nnn + {4'd0, r_v[0]};
                    4'hC: begin
                        w_v_we = 1'b1; w_v_d = r_req.rnd_byte & w_nn;
                    end
                    4'hD: begin
                        n_hit = 1'b0;
                        n_st  = ST_DRAW_RD;
                    end
                    4'hE: begin
                        if (w_nn == 8'h9E) begin
                            if (r_req.keys[w_vx[3:0]]) n_pc = w_pc2;
                        end else if (w_nn == 8'hA1) begin
                            if (!r_req.keys[w_vx[3:0]]) n_pc = w_pc2;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    default: begin
                        case (w_nn)
                            8'h07: begin
                                w_v_we = 1'b1; w_v_d = r_dt;
                            end
                            8'h0A: begin
                                if (w_keyf) begin
                                    w_v_we = 1'b1; w_v_d = {3'd0, w_key};
                                end else begin
                                    n_pc = r_pc - 12'd2; n_wait = 1'b1;
                                end
                            end
                            8'h15: n_dt = w_vx;
                            8'h18: n_snd = w_vx;
                            8'h1E: n_i = r_i + {8'd0, w_vx};
                            8'h29: n_i = 16'(GLYPH_BASE) + {6'd0, w_vx, 2'd0}
                                         + {8'd0, w_vx};
                            8'h33: begin
                                n_t = w_vx; n_sp = 8'd0; n_st = ST_BCD_DIV;
                            end
                            8'h55: n_st = ST_BLK_ST;
                            8'h65: n_st = ST_BLK_RD;
                            default: n_bad = 1'b1;
                        endcase
                    end
                endcase
            end
            ST_STK_RD: begin
                w_stk_a = SW'(r_sl);
                n_st    = ST_STK_W;
            end
            ST_STK_W: begin
                n_pc = r_stk_q;
                n_st = ST_DONE;
            end
            ST_CLS: begin
                w_fb_we = 1'b1;
                w_fb_a  = YW'(r_cnt);
                w_fb_d  = '0;
                n_cnt   = r_cnt + 12'd1;
                if (32'(r_cnt) == SCREEN_HEIGHT - 1) n_st = ST_DONE;
            end
            ST_DRAW_RD: begin
                if (r_cnt[4:0] == {1'b0, w_n}) begin
                    w_vf_we = 1'b1; w_vf_d = {7'd0, r_hit};
                    n_st = ST_DONE;
                end else begin
                    w_mem_a = r_i[11:0] + r_cnt;
                    n_st    = ST_DRAW_W;
                end
            end
            ST_DRAW_W: begin
                w_mem_a = r_i[11:0] + r_cnt;
                n_st    = ST_DRAW_ROW;
            end
            ST_DRAW_ROW: begin
                if ((r_fb_q & w_mask) != '0) n_hit = 1'b1;
                w_fb_we = 1'b1;
                n_cnt   = r_cnt + 12'd1;
                n_st    = ST_DRAW_RD;
            end
            ST_DRAW_WR: n_st = ST_DRAW_RD;
            ST_BCD_DIV: begin
                if (r_sp[1:0] == 2'd0 && r_t >= 8'd100) begin
                    n_t = r_t - 8'd100; n_op[15:8] = r_op[15:8];
                    n_cnt = r_cnt + 12'd1;
                end else if (r_sp[1:0] == 2'd1 && r_t >= 8'd10) begin
                    n_t = r_t - 8'd10; n_cnt = r_cnt + 12'd1;
                end else begin
                    n_st = ST_BCD_WR;
                end
            end
            ST_BCD_WR: begin
                w_mem_we = 1'b1;
                w_mem_a  = r_i[11:0] + {10'd0, r_sp[1:0]};
                w_mem_d  = (r_sp[1:0] == 2'd2) ? r_t : r_cnt[7:0];
                n_cnt    = 12'd0;
                n_sp     = r_sp + 8'd1;
                n_st     = (r_sp[1:0] == 2'd2) ? ST_DONE : ST_BCD_DIV;
            end
            ST_BLK_ST: begin
                w_mem_we = 1'b1;
                w_mem_a  = r_i[11:0] + r_cnt;
                w_mem_d  = r_v[r_cnt[3:0]];
                n_cnt    = r_cnt + 12'd1;
                if (r_cnt[3:0] == w_x) n_st = ST_DONE;
            end
            ST_BLK_RD: begin
                w_mem_a = r_i[11:0] + r_cnt;
                n_st    = ST_BLK_W;
            end
            ST_BLK_W: begin
                w_mem_a = r_i[11:0] + r_cnt;
                n_st    = ST_BLK_LD;
            end
            ST_BLK_LD: begin
                w_v_we = 1'b1; w_v_a = r_cnt[3:0]; w_v_d = r_mem_q;
                n_cnt  = r_cnt + 12'd1;
                n_st   = (r_cnt[3:0] == w_x) ? ST_DONE : ST_BLK_RD;
            end
            ST_DONE: begin
                n_rsp.pc_now = r_pc;
                if (r_req.func == FUNC_STEP) begin
                    n_rsp.last_opcode = r_op;
                    n_rsp.bad_opcode  = r_bad;
                    n_rsp.key_wait    = r_wait;
                    n_rsp.beep        = (r_snd == 8'd1);
                    if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                    if (r_snd != 8'd0) n_snd = r_snd - 8'd1;
                end
                n_st = ST_OUT;
            end
            ST_OUT: begin
                if (i_ready) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

endmodule
